FILE: rtl/core/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int DIV_STEPS   = DATA_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [1:0] REQ_PUSH     = 2'd0;
    localparam logic [1:0] REQ_OPERATOR = 2'd1;
    localparam logic [1:0] REQ_FINISH   = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DIV_ZERO = 3'd1;
    localparam logic [2:0] ST_BAD_OP   = 3'd2;
    localparam logic [2:0] ST_FEW      = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_LEFTOVER = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] number_value;
        logic [2:0]               operator_code;
    } t_req;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [4:0]               stack_count;
        logic                     expression_done;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_WRITE
    } t_state;

endpackage

FILE: rtl/core/postfix_stack_calculator.sv
`timescale 1ns / 1ps

// Channel   Ports                     Handshake
// item in   i_req (t_req)             accepted when start is high and busy is low
// result    o_rsp (t_rsp)             valid for one cycle while o_valid is high
//
// Push, finish, ignored request types and operators that fail their checks return their
// result in the next cycle and busy stays low.
// Add, subtract and multiply step through read of the left operand, execute and write.
// Divide runs a radix-2 divider state after execute that retires one quotient bit a cycle.
// Synchronous active-low reset empties the stack and clears the sticky error.
// Results cannot be stalled; each one is shown for exactly one cycle.
module postfix_stack_calculator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  psc_pkg::t_req   i_req,
    output logic            o_valid,
    output psc_pkg::t_rsp   o_rsp
);
    import psc_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [2:0]        r_err, n_err;
    logic [DATA_W-1:0] r_top, n_top;
    logic [2:0]        r_op, n_op;
    logic [PTR_W-1:0]  r_rd_addr, n_rd_addr;
    logic [DATA_W-1:0] r_lhs;
    logic [DATA_W-1:0] r_res, n_res;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic              r_neg, n_neg;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_valid, n_valid;
    t_rsp              r_rsp, n_rsp;

    logic              w_we;
    logic [PTR_W-1:0]  w_waddr;
    logic [DATA_W-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_lhs <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_err   <= ST_OK;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            r_valid <= n_valid;
        end
        r_top     <= n_top;
        r_op      <= n_op;
        r_rd_addr <= n_rd_addr;
        r_res     <= n_res;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_dvs     <= n_dvs;
        r_neg     <= n_neg;
        r_step    <= n_step;
        r_rsp     <= n_rsp;
    end

    always_comb begin
        logic [DATA_W:0]   trial;
        logic [DATA_W:0]   diff;
        logic [DATA_W-1:0] lhs_mag;
        logic [DATA_W-1:0] rhs_mag;
        logic [DATA_W-1:0] result;

        n_state   = r_state;
        n_count   = r_count;
        n_err     = r_err;
        n_top     = r_top;
        n_op      = r_op;
        n_rd_addr = r_rd_addr;
        n_res     = r_res;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_neg     = r_neg;
        n_step    = r_step;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        w_we      = 1'b0;
        w_waddr   = r_rd_addr;
        w_wdata   = r_top;

        trial   = {r_rem, r_quo[DATA_W-1]};
        diff    = trial - {1'b0, r_dvs};
        lhs_mag = r_lhs[DATA_W-1] ? (DATA_W'(0) - r_lhs) : r_lhs;
        rhs_mag = r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;
        result  = (r_op == OP_DIV) ? (r_neg ? (DATA_W'(0) - r_quo) : r_quo) : r_res;

        busy = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_req.operator_code;
                    n_valid = 1'b1;
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            if (r_err == ST_OK) begin
                                if (r_count >= CNT_W'(STACK_DEPTH)) begin
                                    n_err = ST_OVERFLOW;
                                end else begin
                                    w_we    = 1'b1;
                                    w_waddr = r_count[PTR_W-1:0];
                                    w_wdata = i_req.number_value;
                                    n_top   = i_req.number_value;
                                    n_count = r_count + CNT_W'(1);
                                end
                            end
                        end
                        REQ_OPERATOR: begin
                            if (r_err == ST_OK) begin
                                if (r_count < CNT_W'(2)) begin
                                    n_err = ST_FEW;
                                end else if (i_req.operator_code != OP_ADD &&
                                             i_req.operator_code != OP_SUB &&
                                             i_req.operator_code != OP_MUL &&
                                             i_req.operator_code != OP_DIV) begin
                                    n_err = ST_BAD_OP;
                                end else if (i_req.operator_code == OP_DIV &&
                                             r_top == '0) begin
                                    n_err = ST_DIV_ZERO;
                                end else begin
                                    // Fetch the left operand; the result follows later.
                                    n_valid   = 1'b0;
                                    n_rd_addr = PTR_W'(r_count - CNT_W'(2));
                                    n_state   = S_READ;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.status          = n_err;
                    n_rsp.top_value       = (n_count == '0) ? '0 : n_top;
                    n_rsp.stack_count     = 5'(n_count);
                    n_rsp.expression_done = 1'b0;
                    if (i_req.req_type == REQ_FINISH) begin
                        n_rsp.top_value       = '0;
                        n_rsp.expression_done = 1'b1;
                        n_rsp.stack_count     = '0;
                        if (r_err != ST_OK) begin
                            n_rsp.status = r_err;
                        end else if (r_count == '0) begin
                            n_rsp.status = ST_EMPTY;
                        end else begin
                            n_rsp.top_value = r_top;
                            n_rsp.status    = (r_count > CNT_W'(1)) ? ST_LEFTOVER : ST_OK;
                        end
                        n_count = '0;
                        n_err   = ST_OK;
                    end
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_op)
                    OP_ADD:  n_res = r_lhs + r_top;
                    OP_SUB:  n_res = r_lhs - r_top;
                    OP_MUL:  n_res = DATA_W'(r_lhs * r_top);
                    default: n_res = r_res;
                endcase
                if (r_op == OP_DIV) begin
                    n_quo   = lhs_mag;
                    n_rem   = '0;
                    n_dvs   = rhs_mag;
                    n_neg   = r_lhs[DATA_W-1] ^ r_top[DATA_W-1];
                    n_step  = STEP_W'(DIV_STEPS - 1);
                    n_state = S_DIV;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DIV: begin
                // Restoring division: one quotient bit shifts in per cycle.
                if (!diff[DATA_W]) begin
                    n_rem = diff[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_rd_addr;
                w_wdata = result;
                n_top   = result;
                n_count = r_count - CNT_W'(1);
                n_valid = 1'b1;
                n_rsp.status          = ST_OK;
                n_rsp.top_value       = result;
                n_rsp.stack_count     = 5'(n_count);
                n_rsp.expression_done = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_err_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_err == ST_OK)
        else $error("sequencer running with a sticky error");

    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type != REQ_OPERATOR) |=> o_valid)
        else $error("single-cycle item gave no result");

    a_finish_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.expression_done) |-> (r_count == '0 && r_err == ST_OK))
        else $error("finish left stack state behind");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (o_valid && !busy && o_rsp.status == ST_OK))
        else $error("operator write did not report a result");

endmodule

FILE: dv/tb_postfix_stack_calculator.sv
`timescale 1ns / 1ps

module tb_postfix_stack_calculator;
    import psc_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CALM_TAIL    = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // Request type 3 has no meaning and must be ignored; code 7 is one of the bad operators.
    localparam logic [1:0] REQ_IGNORED = 2'd3;
    localparam logic [2:0] OP_BAD      = 3'd7;

    typedef struct {
        t_req tok;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_valid;
    t_req i_req;
    t_rsp o_rsp;

    postfix_stack_calculator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // Operand stack as the calculator should hold it.
    logic [DATA_W-1:0] model_stack [STACK_DEPTH];
    int                model_depth;
    logic [2:0]        model_err;

    t_rsp expected_q [$];
    bit   item_taken;
    bit   cur_typed;
    t_rsp cur_rsp;
    bit   idle_on;
    int   items_sent;
    int   items_accepted;
    int   results_checked;
    int   mismatches;
    int   cycle_count;
    int   finishes;
    int   status_hits [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] model_top();
        if (model_depth == 0) return '0;
        return model_stack[model_depth-1];
    endfunction

    function automatic t_rsp calc_token(input t_req tok);
        t_rsp              r;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        bit                wrote;
        r     = '0;
        res   = '0;
        wrote = 1'b0;
        case (tok.req_type)
            REQ_PUSH: begin
                if (model_err == ST_OK) begin
                    if (model_depth >= STACK_DEPTH) begin
                        model_err = ST_OVERFLOW;
                    end else begin
                        model_stack[model_depth] = tok.number_value;
                        model_depth++;
                    end
                end
            end
            REQ_OPERATOR: begin
                // The operand count is checked before the operator code.
                if (model_err == ST_OK && model_depth < 2) begin
                    model_err = ST_FEW;
                end else if (model_err == ST_OK) begin
                    rhs   = model_stack[model_depth-1];
                    lhs   = model_stack[model_depth-2];
                    wrote = 1'b1;
                    case (tok.operator_code)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        OP_DIV: begin
                            if (rhs == '0) begin
                                model_err = ST_DIV_ZERO;
                                wrote     = 1'b0;
                            end else begin
                                res = 32'(longint'($signed(lhs)) / longint'($signed(rhs)));
                            end
                        end
                        default: begin
                            model_err = ST_BAD_OP;
                            wrote     = 1'b0;
                        end
                    endcase
                    if (wrote) begin
                        model_depth--;
                        model_stack[model_depth-1] = res;
                    end
                end
            end
            REQ_FINISH: begin
                r.expression_done = 1'b1;
                if (model_err != ST_OK) begin
                    r.status = model_err;
                end else if (model_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.top_value = model_top();
                    r.status    = (model_depth > 1) ? ST_LEFTOVER : ST_OK;
                end
                model_depth = 0;
                model_err   = ST_OK;
                return r;
            end
            default: ;
        endcase
        r.status      = model_err;
        r.top_value   = model_top();
        r.stack_count = 5'(model_depth);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    // Acceptance and result checking both happen at the rising edge.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp predicted;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time, expected_q.size());
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && start && !busy) begin
            predicted = calc_token(i_req);
            expected_q.push_back(cur_typed ? cur_rsp : predicted);
            item_taken = 1'b1;
            items_accepted++;
        end
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with nothing expected, actual %p", $time, o_rsp);
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                status_hits[o_rsp.status]++;
                if (o_rsp.expression_done === 1'b1) finishes++;
                if (o_rsp.status !== want.status)
                    report_field("status", 32'(want.status), 32'(o_rsp.status));
                if (o_rsp.top_value !== want.top_value)
                    report_field("top_value", want.top_value, o_rsp.top_value);
                if (o_rsp.stack_count !== want.stack_count)
                    report_field("stack_count", 32'(want.stack_count), 32'(o_rsp.stack_count));
                if (o_rsp.expression_done !== want.expression_done)
                    report_field("expression_done", 32'(want.expression_done),
                                 32'(o_rsp.expression_done));
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item was taken.
    task automatic send_item(input t_req tok, input bit typed, input t_rsp rsp);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_typed  = typed;
        cur_rsp    = rsp;
        item_taken = 1'b0;
        start <= 1'b1;
        i_req <= tok;
        do @(negedge i_clk); while (!item_taken);
        items_sent++;
    endtask

    function automatic t_row row(input logic [1:0] rt, input logic [31:0] num,
                                 input logic [2:0] op, input bit typed, input logic [2:0] st,
                                 input logic [31:0] top, input logic [4:0] cnt, input bit done);
        t_row r;
        r.tok.req_type              = rt;
        r.tok.number_value          = num;
        r.tok.operator_code         = op;
        r.typed                     = typed;
        r.rsp.status                = st;
        r.rsp.top_value             = top;
        r.rsp.stack_count           = cnt;
        r.rsp.expression_done       = done;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom_range(0, 40) - 20;
            3: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    3: return 32'h0;
                    default: return 32'h1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req push_tok();
        t_req tok;
        tok.req_type      = REQ_PUSH;
        tok.number_value  = rand_operand();
        tok.operator_code = 3'($urandom);
        return tok;
    endfunction

    function automatic t_req op_tok();
        t_req tok;
        tok.req_type      = REQ_OPERATOR;
        tok.number_value  = $urandom;
        tok.operator_code = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(4, 7))
                                                         : 3'($urandom_range(0, 3));
        return tok;
    endfunction

    function automatic t_req finish_tok();
        t_req tok;
        tok.req_type      = REQ_FINISH;
        tok.number_value  = $urandom;
        tok.operator_code = 3'($urandom);
        return tok;
    endfunction

    // A well-formed expression with random operands, usually reduced to one value.
    task automatic run_expression();
        int depth;
        int steps;
        depth = 0;
        steps = $urandom_range(1, 24);
        repeat (steps) begin
            if (depth < 2 || (depth < STACK_DEPTH && $urandom_range(0, 1) == 0)) begin
                send_item(push_tok(), 1'b0, '0);
                depth++;
            end else begin
                send_item(op_tok(), 1'b0, '0);
                depth--;
            end
        end
        if ($urandom_range(0, 7) != 0) begin
            while (depth > 1) begin
                send_item(op_tok(), 1'b0, '0);
                depth--;
            end
        end
        send_item(finish_tok(), 1'b0, '0);
    endtask

    // Pushes between one fewer than the stack depth and two more than it, so it sometimes overflows.
    task automatic run_fill();
        int depth;
        depth = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2);
        repeat (depth) send_item(push_tok(), 1'b0, '0);
        if ($urandom_range(0, 1) == 0) begin
            if (depth > STACK_DEPTH) depth = STACK_DEPTH;
            while (depth > 1) begin
                send_item(op_tok(), 1'b0, '0);
                depth--;
            end
        end
        send_item(finish_tok(), 1'b0, '0);
    endtask

    // Arbitrary requests, including the unused request type.
    task automatic run_noise();
        t_req tok;
        repeat ($urandom_range(1, 8)) begin
            tok.req_type      = 2'($urandom);
            tok.number_value  = $urandom;
            tok.operator_code = 3'($urandom);
            send_item(tok, 1'b0, '0);
        end
        if ($urandom_range(0, 1) == 0) send_item(finish_tok(), 1'b0, '0);
    endtask

    initial begin
        t_row plan [$];
        int   random_goal;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        cur_typed   = 1'b0;
        cur_rsp     = '0;
        item_taken  = 1'b0;
        idle_on     = 1'b1;
        model_depth = 0;
        model_err   = ST_OK;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes, wrap-around and the most negative value divided by minus one.
        plan.push_back(row(REQ_FINISH,   32'h0,         OP_ADD, 1, ST_EMPTY, 32'h0, 0, 1));
        plan.push_back(row(REQ_PUSH,     32'h7fff_ffff, OP_DIV, 1, ST_OK, 32'h7fff_ffff, 1, 0));
        plan.push_back(row(REQ_PUSH,     32'h1,         OP_BAD, 1, ST_OK, 32'h1, 2, 0));
        plan.push_back(row(REQ_OPERATOR, 32'hffff_ffff, OP_ADD, 1, ST_OK, 32'h8000_0000, 1, 0));
        plan.push_back(row(REQ_PUSH,     32'hffff_ffff, OP_SUB, 1, ST_OK, 32'hffff_ffff, 2, 0));
        plan.push_back(row(REQ_OPERATOR, 32'h0,         OP_DIV, 1, ST_OK, 32'h8000_0000, 1, 0));
        plan.push_back(row(REQ_PUSH,     32'h8000_0000, OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_OPERATOR, 32'h0,         OP_MUL, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_PUSH,     32'h3,         OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_OPERATOR, 32'h0,         OP_SUB, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_FINISH,   32'h0,         OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        // An operator on an empty stack makes the error sticky until the finish.
        plan.push_back(row(REQ_OPERATOR, 32'h0,         OP_ADD, 1, ST_FEW, 32'h0, 0, 0));
        plan.push_back(row(REQ_PUSH,     32'h5,         OP_ADD, 1, ST_FEW, 32'h0, 0, 0));
        plan.push_back(row(REQ_FINISH,   32'h0,         OP_ADD, 1, ST_FEW, 32'h0, 0, 1));
        // Division by zero leaves both operands in place.
        plan.push_back(row(REQ_PUSH,     32'hffff_fff9, OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_PUSH,     32'h0,         OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_OPERATOR, 32'h0,         OP_DIV, 1, ST_DIV_ZERO, 32'h0, 2, 0));
        plan.push_back(row(REQ_IGNORED,  32'h1234_5678, OP_ADD, 1, ST_DIV_ZERO, 32'h0, 2, 0));
        plan.push_back(row(REQ_FINISH,   32'h0,         OP_ADD, 1, ST_DIV_ZERO, 32'h0, 0, 1));
        // Truncating division, then a bad operator code.
        plan.push_back(row(REQ_PUSH,     32'h9,         OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_PUSH,     32'hffff_fffe, OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_OPERATOR, 32'h0,         OP_DIV, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_PUSH,     32'h2,         OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_OPERATOR, 32'h0,         OP_BAD, 1, ST_BAD_OP, 32'h2, 2, 0));
        plan.push_back(row(REQ_FINISH,   32'h0,         OP_ADD, 1, ST_BAD_OP, 32'h0, 0, 1));
        // Operands left over at the finish.
        plan.push_back(row(REQ_PUSH,     32'h1,         OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_PUSH,     32'h2,         OP_ADD, 0, ST_OK, 32'h0, 0, 0));
        plan.push_back(row(REQ_FINISH,   32'h0,         OP_ADD, 1, ST_LEFTOVER, 32'h2, 0, 1));

        foreach (plan[i]) send_item(plan[i].tok, plan[i].typed, plan[i].rsp);

        random_goal = items_sent + RANDOM_ITEMS;
        run_fill();
        while (items_sent < random_goal) begin
            idle_on = (items_sent < random_goal - CALM_TAIL);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: run_expression();
                7: run_fill();
                default: run_noise();
            endcase
        end
        start <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items and checked %0d results, %0d of them ending an expression.",
                 items_accepted, results_checked, finishes);
        $display("Statuses ok/dz/bad/few/empty/left/ovf: %0d %0d %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6]);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/psc_pkg.sv
rtl/core/postfix_stack_calculator.sv
dv/tb_postfix_stack_calculator.sv
